[design/k_best_list_extender_macros.svh]
// Assertion macros used by the checker file of the list extender
`ifndef K_BEST_LIST_EXTENDER_MACROS_SVH
`define K_BEST_LIST_EXTENDER_MACROS_SVH

// clocked assertion, switched off while reset is held
`define KBLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KBLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/kble_pkg.sv]
// Package of the list extender: sizes, types, register codes and helpers
`timescale 1ns / 1ps

package kble_pkg;

  localparam int KEEP_MAX   = 8;
  localparam int CANDS_MAX  = 8;
  localparam int STAGES_MAX = 8;
  localparam int SEG_MAX    = 64;

  localparam int MET_W  = 24;
  localparam int BITS_W = 64;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 1 + 2 * IDX_W;
  localparam int MEM_DEPTH = 2 * KEEP_MAX * STAGES_MAX;

  localparam logic signed [MET_W-1:0] MET_MAX = 24'sh7FFFFF;
  localparam logic signed [MET_W-1:0] MET_MIN = 24'sh800000;

  // configuration register indexes
  localparam logic [1:0] REG_CANDS  = 2'd0;
  localparam logic [1:0] REG_KEEP   = 2'd1;
  localparam logic [1:0] REG_STAGES = 2'd2;
  localparam logic [1:0] REG_SEGLEN = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_COPY,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // one insertion request to the ranker
  typedef struct packed {
    logic                    en;
    logic                    clr;
    logic [IDX_W-1:0]        parent;
    logic [IDX_W-1:0]        cand;
    logic signed [MET_W-1:0] metric;
  } ins_req_t;

  // zero reads as one, anything above hi reads as hi
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // saturating 24-bit add
  function automatic logic signed [MET_W-1:0] sat_add(input logic signed [MET_W-1:0] a,
                                                      input logic signed [MET_W-1:0] b);
    logic signed [MET_W:0] s;
    logic signed [MET_W-1:0] r;
    s = {a[MET_W-1], a} + {b[MET_W-1], b};
    r = s[MET_W-1:0];
    if (s[MET_W] != s[MET_W-1]) r = s[MET_W] ? MET_MIN : MET_MAX;
    return r;
  endfunction

endpackage

[design/kble_ranker.sv]
// Sorted list of the best paths of a stage, one insertion per cycle
`timescale 1ns / 1ps

module kble_ranker import kble_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ins_req_t                req,
  input  logic [CNT_W-1:0]        len_l,
  input  logic [CNT_W-1:0]        keep,
  output logic [IDX_W-1:0]        rk_par  [KEEP_MAX],
  output logic [IDX_W-1:0]        rk_cand [KEEP_MAX],
  output logic signed [MET_W-1:0] rk_met  [KEEP_MAX],
  output logic [CNT_W-1:0]        rk_cnt
);

  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        par_r  [KEEP_MAX];
  logic [IDX_W-1:0]        cand_r [KEEP_MAX];
  logic signed [MET_W-1:0] met_r  [KEEP_MAX];

  logic [7:0]       new_idx;
  logic [7:0]       ent_idx [KEEP_MAX];
  logic [KEEP_MAX-1:0] ahead;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] top;
  logic             found;

  // count truncated to the current keep size
  assign rk_cnt = (cnt_r > keep) ? keep : cnt_r;

  // compare lanes: does the new path rank ahead of each entry
  always_comb begin
    new_idx = 8'(req.parent) * 8'(len_l) + 8'(req.cand);
    for (int i = 0; i < KEEP_MAX; i++) begin
      ent_idx[i] = 8'(par_r[i]) * 8'(len_l) + 8'(cand_r[i]);
      ahead[i]   = (CNT_W'(i) < rk_cnt) &&
                   ((req.metric > met_r[i]) ||
                    ((req.metric == met_r[i]) && (new_idx < ent_idx[i])));
    end
  end

  // first entry the new path beats; the end of the list otherwise
  always_comb begin
    pos   = rk_cnt;
    found = 1'b0;
    for (int i = 0; i < KEEP_MAX; i++) begin
      if (ahead[i] && !found) begin
        pos   = CNT_W'(i);
        found = 1'b1;
      end
    end
    top = (rk_cnt < keep) ? rk_cnt : keep - CNT_W'(1);
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      cnt_r <= '0;
    end else if (req.en) begin
      cnt_r <= (pos < keep && rk_cnt < keep) ? rk_cnt + CNT_W'(1) : rk_cnt;
    end
  end

  // shift lower entries down and drop the new path in
  always_ff @(posedge clk) begin
    if (req.en && pos < keep) begin
      for (int i = 0; i < KEEP_MAX; i++) begin
        if (CNT_W'(i) == pos) begin
          par_r[i]  <= req.parent;
          cand_r[i] <= req.cand;
          met_r[i]  <= req.metric;
        end else if (i > 0 && CNT_W'(i) > pos && CNT_W'(i) <= top) begin
          par_r[i]  <= par_r[i-1];
          cand_r[i] <= cand_r[i-1];
          met_r[i]  <= met_r[i-1];
        end
      end
    end
  end

  assign rk_par  = par_r;
  assign rk_cand = cand_r;
  assign rk_met  = met_r;

endmodule

[design/kble_seg_mem.sv]
// Segment store: two banks of survivor segments, one write and one read port
`timescale 1ns / 1ps

module kble_seg_mem import kble_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [BITS_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [BITS_W-1:0] rdata_r
);

  logic [BITS_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

endmodule

[design/k_best_list_extender.sv]
// Top level of the K-best list extender: sequencer, survivor state and ports
//
// Candidates arrive one word per start pulse, stage by stage. A candidate
// keeps busy high while the shared ranker takes its pairings with the S
// survivors (S being the survivor count), one survivor pairing per cycle. The
// last candidate of a stage then copies the kept paths' segments through
// the segment store (R kept paths) and commits them.
// The last candidate of a codeword then streams R*stages result words, one
// per cycle on out_valid, each read from the segment store and registered;
// the receiver has no way to stall them and must take each in its
// cycle. Configuration should be written only while busy is low and the
// last result has gone.
`timescale 1ns / 1ps

module k_best_list_extender import kble_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [BITS_W-1:0]       in_seg_bits,
  input  logic signed [MET_W-1:0] in_metric,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_rank,
  output logic [IDX_W-1:0]        out_seg_index,
  output logic [BITS_W-1:0]       out_bits,
  output logic signed [MET_W-1:0] out_total_metric,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [6:0]              cfg_data
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] cands_r, keep_r, stages_r;
  logic [6:0]       seglen_r;
  logic [CNT_W-1:0] len_l, keep_n, stages_n;
  logic [6:0]       slen;
  logic [BITS_W-1:0] mask;

  logic signed [MET_W-1:0] m_r;
  logic [IDX_W-1:0] k_r, j_r, cand_cnt_r, cr_r, cs_r;
  logic [CNT_W-1:0] stage_r, surv_cnt_r;
  logic             bank_r;
  logic signed [MET_W-1:0] surv_met_r [KEEP_MAX];
  logic [BITS_W-1:0]       cand_bits_r [CANDS_MAX];

  logic              cp_vld_r, cp_new_r;
  logic [ADDR_W-1:0] cp_waddr_r;
  logic [BITS_W-1:0] cp_bits_r;

  logic              ov_r, last_r;
  logic [IDX_W-1:0]  rank_r, seg_r;
  logic signed [MET_W-1:0] tmet_r;

  ins_req_t          req;
  logic [IDX_W-1:0]        rk_par  [KEEP_MAX];
  logic [IDX_W-1:0]        rk_cand [KEEP_MAX];
  logic signed [MET_W-1:0] rk_met  [KEEP_MAX];
  logic [CNT_W-1:0]        rk_cnt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BITS_W-1:0] mem_wdata, mem_rdata;

  logic accept, ins_last, stage_end, seg_last, copy_last, emit_last, cw_end;

  // effective register values
  assign len_l    = clamp_cnt(cands_r, CNT_W'(CANDS_MAX));
  assign keep_n   = clamp_cnt(keep_r, CNT_W'(KEEP_MAX));
  assign stages_n = clamp_cnt(stages_r, CNT_W'(STAGES_MAX));
  assign slen     = (seglen_r > 7'(SEG_MAX)) ? 7'(SEG_MAX) : seglen_r;

  always_comb begin
    for (int n = 0; n < BITS_W; n++) mask[n] = (7'(n) < slen);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cands_r  <= CNT_W'(4);
      keep_r   <= CNT_W'(8);
      stages_r <= CNT_W'(4);
      seglen_r <= 7'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANDS:  cands_r  <= cfg_data[CNT_W-1:0];
        REG_KEEP:   keep_r   <= cfg_data[CNT_W-1:0];
        REG_STAGES: stages_r <= cfg_data[CNT_W-1:0];
        REG_SEGLEN: seglen_r <= cfg_data;
      endcase
    end
  end

  // sequencer conditions
  assign accept    = start && (state_r == ST_IDLE);
  assign ins_last  = (surv_cnt_r == '0) || ({1'b0, j_r} + CNT_W'(1) >= surv_cnt_r);
  assign stage_end = ({1'b0, k_r} + CNT_W'(1) >= len_l);
  assign seg_last  = ({1'b0, cs_r} == stage_r);
  assign copy_last = seg_last && ({1'b0, cr_r} + CNT_W'(1) >= rk_cnt);
  assign cw_end    = (stage_r + CNT_W'(1) >= stages_n);
  assign emit_last = ({1'b0, cr_r} + CNT_W'(1) >= surv_cnt_r) &&
                     ({1'b0, cs_r} + CNT_W'(1) >= stage_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_INSERT;
      ST_INSERT: if (ins_last) state_nxt = stage_end ? ST_COPY : ST_IDLE;
      ST_COPY:   if (copy_last) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = cw_end ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (emit_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencer outputs
  always_comb begin
    busy       = (state_r != ST_IDLE);
    req.en     = (state_r == ST_INSERT);
    req.clr    = (state_r == ST_COMMIT);
    req.parent = (surv_cnt_r == '0) ? '0 : j_r;
    req.cand   = k_r;
    req.metric = (surv_cnt_r == '0) ? m_r : sat_add(surv_met_r[j_r], m_r);
    mem_re     = 1'b0;
    mem_raddr  = {bank_r, rk_par[cr_r], cs_r};
    unique case (state_r)
      ST_COPY: mem_re = !seg_last;
      ST_EMIT: begin
        mem_re    = 1'b1;
        mem_raddr = {bank_r, cr_r, cs_r};
      end
      default: mem_re = 1'b0;
    endcase
  end

  // item capture and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_cnt_r <= '0;
      stage_r    <= '0;
      surv_cnt_r <= '0;
      bank_r     <= 1'b0;
      j_r        <= '0;
      cr_r       <= '0;
      cs_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          j_r <= '0;
          cr_r <= '0;
          cs_r <= '0;
        end
        ST_INSERT: begin
          j_r <= j_r + IDX_W'(1);
          if (ins_last && !stage_end) cand_cnt_r <= cand_cnt_r + IDX_W'(1);
        end
        ST_COPY: begin
          if (seg_last) begin
            cs_r <= '0;
            cr_r <= cr_r + IDX_W'(1);
          end else begin
            cs_r <= cs_r + IDX_W'(1);
          end
        end
        ST_COMMIT: begin
          surv_cnt_r <= rk_cnt;
          cand_cnt_r <= '0;
          bank_r     <= ~bank_r;
          stage_r    <= stage_r + CNT_W'(1);
          cr_r       <= '0;
          cs_r       <= '0;
        end
        ST_EMIT: begin
          if ({1'b0, cs_r} + CNT_W'(1) >= stage_r) begin
            cs_r <= '0;
            cr_r <= cr_r + IDX_W'(1);
          end else begin
            cs_r <= cs_r + IDX_W'(1);
          end
          if (emit_last) begin
            surv_cnt_r <= '0;
            stage_r    <= '0;
          end
        end
        default: cr_r <= '0;
      endcase
    end
  end

  // payload captured at accept, survivor metrics at commit
  always_ff @(posedge clk) begin
    if (accept) begin
      m_r <= in_metric;
      k_r <= cand_cnt_r;
      cand_bits_r[cand_cnt_r] <= in_seg_bits & mask;
    end
    if (state_r == ST_COMMIT) begin
      for (int i = 0; i < KEEP_MAX; i++) surv_met_r[i] <= rk_met[i];
    end
  end

  // copy pipe: old segment read, written to the other bank in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) cp_vld_r <= 1'b0;
    else        cp_vld_r <= (state_r == ST_COPY);
  end

  always_ff @(posedge clk) begin
    cp_waddr_r <= {~bank_r, cr_r, cs_r};
    cp_new_r   <= seg_last;
    cp_bits_r  <= cand_bits_r[rk_cand[cr_r]];
  end

  assign mem_we    = cp_vld_r;
  assign mem_wdata = cp_new_r ? cp_bits_r : mem_rdata;

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= (state_r == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    rank_r <= cr_r;
    seg_r  <= cs_r;
    tmet_r <= surv_met_r[cr_r];
    last_r <= emit_last;
  end

  assign out_valid        = ov_r;
  assign out_rank         = rank_r;
  assign out_seg_index    = seg_r;
  assign out_bits         = mem_rdata;
  assign out_total_metric = tmet_r;
  assign out_last         = last_r;

  kble_ranker u_ranker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .len_l   (len_l),
    .keep    (keep_n),
    .rk_par  (rk_par),
    .rk_cand (rk_cand),
    .rk_met  (rk_met),
    .rk_cnt  (rk_cnt)
  );

  kble_seg_mem u_seg_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (cp_waddr_r),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule

[design/kble_checker.sv]
// Port-level checks of the list extender, bound to the top level
`timescale 1ns / 1ps
`include "k_best_list_extender_macros.svh"

module kble_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  `KBLE_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `KBLE_ASSERT(a_last_ends, out_valid && out_last |=> !out_valid, "result after last word")
  `KBLE_ASSERT(a_stream_gapless, out_valid && !out_last |=> out_valid, "gap in result stream")
  `KBLE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy, "activity after reset")

endmodule

bind k_best_list_extender kble_checker u_kble_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);

[verif/k_best_list_extender_tb.sv]
// Testbench of the K-best list extender: directed and random codewords, self-checking
`timescale 1ns / 1ps

module k_best_list_extender_tb;
  import kble_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic [BITS_W-1:0] bits;
    logic [MET_W-1:0]  metric;
  } cand_word_t;

  typedef struct {
    logic [IDX_W-1:0]  rank;
    logic [IDX_W-1:0]  seg_index;
    logic [BITS_W-1:0] bits;
    logic [MET_W-1:0]  metric;
    logic              last;
  } path_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [BITS_W-1:0]       in_seg_bits = '0;
  logic signed [MET_W-1:0] in_metric = '0;
  logic                    out_valid;
  logic [IDX_W-1:0]        out_rank;
  logic [IDX_W-1:0]        out_seg_index;
  logic [BITS_W-1:0]       out_bits;
  logic signed [MET_W-1:0] out_total_metric;
  logic                    out_last;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [6:0]              cfg_data = '0;

  k_best_list_extender u_top (.*);

  always #10 clk = ~clk;

  // pending candidates, expected paths and bookkeeping
  cand_word_t cand_q[$];
  path_word_t path_q[$];
  cand_word_t cur_cand;
  int  gap_left = 0;
  bit  no_idle = 1'b0;
  int  errors = 0;
  int  quiet_cycles = 0;

  // shadow of the block's registers and path state
  logic [3:0]  sh_cands = 4'd4, sh_keep = 4'd8, sh_stages = 4'd4;
  logic [6:0]  sh_seglen = 7'd16;
  logic [BITS_W-1:0] surv_bits [KEEP_MAX*STAGES_MAX];
  int          surv_met [KEEP_MAX];
  int          surv_cnt = 0;
  logic [BITS_W-1:0] stage_bits [CANDS_MAX];
  int          rk_parent [KEEP_MAX];
  int          rk_cand [KEEP_MAX];
  int          rk_met [KEEP_MAX];
  int          rk_cnt = 0;
  int          stage_no = 0;
  int          cand_no = 0;

  function automatic int clampv(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int sat_met(int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // insert one pairing into the sorted kept list
  function automatic void rank_insert(int parent, int cand, int m, int lc, int keep);
    int idx, pos, i;
    idx = parent * lc + cand;
    pos = 0;
    if (rk_cnt > keep) rk_cnt = keep;
    while (pos < rk_cnt && !((m != rk_met[pos]) ? (m > rk_met[pos]) :
                             (idx < rk_parent[pos] * lc + rk_cand[pos])))
      pos++;
    if (pos >= keep) return;
    i = (rk_cnt < keep) ? rk_cnt : keep - 1;
    while (i > pos) begin
      rk_parent[i] = rk_parent[i-1];
      rk_cand[i]   = rk_cand[i-1];
      rk_met[i]    = rk_met[i-1];
      i--;
    end
    rk_parent[pos] = parent;
    rk_cand[pos]   = cand;
    rk_met[pos]    = m;
    if (rk_cnt < keep) rk_cnt++;
  endfunction

  // advance the shadow state by one candidate word, queue any paths it finishes
  function automatic void extend_paths(cand_word_t c);
    logic [BITS_W-1:0] tmp [KEEP_MAX*STAGES_MAX];
    logic [BITS_W-1:0] mask;
    path_word_t pw;
    int lc, keep, stg, slen, m, k, segs, total, n;
    lc   = clampv(sh_cands, CANDS_MAX);
    keep = clampv(sh_keep, KEEP_MAX);
    stg  = clampv(sh_stages, STAGES_MAX);
    slen = (sh_seglen > SEG_MAX) ? SEG_MAX : sh_seglen;
    mask = (slen >= 64) ? '1 : ((64'd1 << slen) - 64'd1);
    m = $signed(c.metric);
    k = (cand_no >= CANDS_MAX) ? CANDS_MAX - 1 : cand_no;
    tmp = surv_bits;
    stage_bits[k] = c.bits & mask;
    if (surv_cnt == 0) rank_insert(0, k, m, lc, keep);
    else for (int j = 0; j < surv_cnt; j++) rank_insert(j, k, sat_met(surv_met[j] + m), lc, keep);
    if (k + 1 < lc) begin
      cand_no = k + 1;
      return;
    end
    // stage end: kept list becomes the survivors
    if (rk_cnt > keep) rk_cnt = keep;
    for (int r = 0; r < rk_cnt; r++) begin
      for (int s = 0; s < stage_no && s < STAGES_MAX; s++)
        tmp[r*STAGES_MAX+s] = surv_bits[(rk_parent[r] % KEEP_MAX)*STAGES_MAX+s];
      if (stage_no < STAGES_MAX)
        tmp[r*STAGES_MAX+stage_no] = stage_bits[rk_cand[r] % CANDS_MAX];
    end
    surv_bits = tmp;
    for (int r = 0; r < rk_cnt; r++) surv_met[r] = rk_met[r];
    surv_cnt = rk_cnt;
    rk_cnt = 0;
    cand_no = 0;
    stage_no++;
    if (stage_no < stg) return;
    // codeword done: every survivor's segments in rank order
    segs = (stage_no > STAGES_MAX) ? STAGES_MAX : stage_no;
    total = surv_cnt * segs;
    n = 0;
    for (int r = 0; r < surv_cnt; r++)
      for (int s = 0; s < segs; s++) begin
        n++;
        pw.rank = r[IDX_W-1:0];
        pw.seg_index = s[IDX_W-1:0];
        pw.bits = surv_bits[r*STAGES_MAX+s];
        pw.metric = surv_met[r][MET_W-1:0];
        pw.last = (n == total);
        path_q.push_back(pw);
      end
    surv_cnt = 0;
    stage_no = 0;
  endfunction

  // driver: one candidate word per accepted start
  always @(posedge clk) begin
    bit taken;
    taken = start && !busy;
    if (rst_n) begin
      if (taken) extend_paths(cur_cand);
      if (!start || taken) begin
        if (gap_left > 0 && !no_idle) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cand_q.size() > 0) begin
          cur_cand = cand_q.pop_front();
          in_seg_bits <= cur_cand.bits;
          in_metric <= cur_cand.metric;
          start <= 1'b1;
          if ($urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 13);
          else gap_left <= 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each result word against the oldest expected path word
  always @(posedge clk) begin
    path_word_t e;
    if (rst_n && out_valid) begin
      if (path_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word rank %0d seg %0d", out_rank,
                                   out_seg_index);
      end else begin
        e = path_q.pop_front();
        if (e.rank !== out_rank || e.seg_index !== out_seg_index || e.bits !== out_bits ||
            e.metric !== out_total_metric || e.last !== out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp r%0d s%0d %h m%0d l%0b, got r%0d s%0d %h m%0d l%0b",
                     e.rank, e.seg_index, e.bits, $signed(e.metric), e.last, out_rank,
                     out_seg_index, out_bits, out_total_metric, out_last);
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (cand_q.size() != 0 || start || busy || path_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CANDS:  sh_cands = val[3:0];
      REG_KEEP:   sh_keep = val[3:0];
      REG_STAGES: sh_stages = val[3:0];
      default:    sh_seglen = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_cand(logic [BITS_W-1:0] b, logic [MET_W-1:0] m);
    cand_word_t c;
    c.bits = b;
    c.metric = m;
    cand_q.push_back(c);
  endtask

  function automatic logic [MET_W-1:0] rand_metric();
    case ($urandom_range(0, 3))
      0: return MET_W'($urandom_range(0, 3));
      1: return MET_MAX - MET_W'($urandom_range(0, 3));
      2: return MET_MIN + MET_W'($urandom_range(0, 3));
      default: return MET_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent, lc, sc, words;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset settings, extremes, ties and saturation in one codeword
    add_cand('1, MET_MAX);
    add_cand('0, MET_MIN);
    add_cand(64'hA5A5_5A5A_F0F0_0F0F, 24'sd0);
    add_cand(64'h5A5A_A5A5_0F0F_F0F0, 24'sd0);
    add_cand(64'h1, MET_MAX);
    add_cand(64'h2, MET_MAX);
    add_cand(64'h3, MET_MIN);
    add_cand(64'h4, 24'sd1);
    for (int i = 0; i < 8; i++) add_cand({$urandom, $urandom}, (i % 2) ? MET_MIN : MET_MAX);
    wait_idle();

    // out-of-range registers: zero counts, oversize counts and segment length
    write_reg(REG_CANDS, 7'd0);
    write_reg(REG_KEEP, 7'd15);
    write_reg(REG_STAGES, 7'd0);
    write_reg(REG_SEGLEN, 7'd0);
    add_cand('1, 24'sd5);
    wait_idle();
    write_reg(REG_CANDS, 7'd15);
    write_reg(REG_KEEP, 7'd0);
    write_reg(REG_STAGES, 7'd2);
    write_reg(REG_SEGLEN, 7'd127);
    for (int i = 0; i < 16; i++) add_cand({$urandom, $urandom}, MET_W'(i % 3));
    sent = 16 + 1 + 16;

    // random phases; the last stretch runs without idling
    while (sent < 165) begin
      wait_idle();
      if (sent > 140) no_idle = 1'b1;
      write_reg(REG_CANDS, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 15))
                                                       : 7'($urandom_range(1, 4)));
      write_reg(REG_KEEP, 7'($urandom_range(0, 15)));
      write_reg(REG_STAGES, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 15))
                                                        : 7'($urandom_range(1, 3)));
      write_reg(REG_SEGLEN, 7'($urandom_range(0, 127)));
      lc = clampv(sh_cands, CANDS_MAX);
      sc = clampv(sh_stages, STAGES_MAX);
      // keep the total near the intended item count
      if (sent + lc * sc > 175) begin
        write_reg(REG_STAGES, 7'd1);
        sc = 1;
      end
      words = lc * sc * ((sent + 2 * lc * sc > 175) ? 1 : int'($urandom_range(1, 2)));
      for (int i = 0; i < words; i++) add_cand({$urandom, $urandom}, rand_metric());
      sent += words;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && path_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/kble_pkg.sv
design/kble_ranker.sv
design/kble_seg_mem.sv
design/k_best_list_extender.sv
design/kble_checker.sv
verif/k_best_list_extender_tb.sv
